// ----- sv/alarm_clock_core_unit_macros.svh -----
// Assertion macros for the alarm clock core.
// ACC_ASSERT_IMP: the consequent must hold in the same cycle as the antecedent.
// ACC_ASSERT_NXT: the consequent must hold in the cycle after the antecedent.
`ifndef ALARM_CLOCK_CORE_UNIT_MACROS_SVH
`define ALARM_CLOCK_CORE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define ACC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
	else $error("assertion failed");
`define ACC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define ACC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ACC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- sv/acc_pkg.sv -----
`timescale 1ns / 1ps
package acc_pkg;

	// Command codes
	localparam logic [2:0] CMD_TICK     = 3'd0;
	localparam logic [2:0] CMD_HOUR_UP  = 3'd1;
	localparam logic [2:0] CMD_HOUR_DN  = 3'd2;
	localparam logic [2:0] CMD_MIN_UP   = 3'd3;
	localparam logic [2:0] CMD_MIN_DN   = 3'd4;
	localparam logic [2:0] CMD_SNOOZE   = 3'd5;
	localparam logic [2:0] CMD_TOGGLE   = 3'd6;
	localparam logic [2:0] CMD_NOP      = 3'd7;

	// Register indexes
	localparam logic REG_TWELVE_HOUR = 1'b0;
	localparam logic REG_SNOOZE      = 1'b1;

	// Time constants
	localparam logic [5:0] SEC_MOD  = 6'd60;
	localparam logic [5:0] MIN_MOD  = 6'd60;
	localparam logic [4:0] HOUR_MOD = 5'd24;
	localparam logic [4:0] NOON     = 5'd12;
	localparam logic [11:0] HOUR_SCALE = 12'd100;
	localparam logic [3:0] SNOOZE_RESET = 4'd1;

	typedef struct packed {
		logic [2:0] cmd;
		logic       edit_alarm;
	} req_t;

	typedef struct packed {
		logic [11:0] shown_time;
		logic        pm;
		logic [11:0] alarm_setting;
		logic        ringing;
		logic        alarm_armed;
		logic        ring_start;
	} rsp_t;

	typedef struct packed {
		logic [5:0] seconds;
		logic [5:0] minutes;
		logic [4:0] hours;
		logic [5:0] alarm_minutes;
		logic [4:0] alarm_hours;
		logic       alarm_enabled;
		logic       is_ringing;
	} clk_state_t;

endpackage

// ----- sv/acc_time_path.sv -----
`timescale 1ns / 1ps
module acc_time_path import acc_pkg::*; (
	input  clk_state_t cur,
	input  req_t       req,
	input  logic       twelve_hour,
	input  logic [3:0] snooze_minutes,
	output clk_state_t nxt,
	output rsp_t       rsp
);

	logic [5:0] sec_inc;
	logic [5:0] min_inc;
	logic [4:0] hour_inc;
	logic [5:0] amin_inc;
	logic [4:0] ahour_inc;
	logic [5:0] min_dec;
	logic [4:0] hour_dec;
	logic [5:0] amin_dec;
	logic [4:0] ahour_dec;
	logic [6:0] snooze_sum;
	logic       match;
	logic       started;
	logic [4:0] disp_hour;
	logic       pm;

	// Wrapping steps for every counter
	always_comb begin
		sec_inc   = (cur.seconds + 6'd1 >= SEC_MOD) ? 6'd0 : cur.seconds + 6'd1;
		min_inc   = (cur.minutes + 6'd1 >= MIN_MOD) ? 6'd0 : cur.minutes + 6'd1;
		hour_inc  = (cur.hours + 5'd1 >= HOUR_MOD) ? 5'd0 : cur.hours + 5'd1;
		amin_inc  = (cur.alarm_minutes + 6'd1 >= MIN_MOD) ? 6'd0 : cur.alarm_minutes + 6'd1;
		ahour_inc = (cur.alarm_hours + 5'd1 >= HOUR_MOD) ? 5'd0 : cur.alarm_hours + 5'd1;
		min_dec   = (cur.minutes == 6'd0 || cur.minutes >= MIN_MOD) ?
			MIN_MOD - 6'd1 : cur.minutes - 6'd1;
		hour_dec  = (cur.hours == 5'd0 || cur.hours >= HOUR_MOD) ?
			HOUR_MOD - 5'd1 : cur.hours - 5'd1;
		amin_dec  = (cur.alarm_minutes == 6'd0 || cur.alarm_minutes >= MIN_MOD) ?
			MIN_MOD - 6'd1 : cur.alarm_minutes - 6'd1;
		ahour_dec = (cur.alarm_hours == 5'd0 || cur.alarm_hours >= HOUR_MOD) ?
			HOUR_MOD - 5'd1 : cur.alarm_hours - 5'd1;
		snooze_sum = {1'b0, cur.alarm_minutes} + {3'b000, snooze_minutes};
	end

	// Apply the command to the state
	always_comb begin
		nxt     = cur;
		match   = 1'b0;
		started = 1'b0;
		unique case (req.cmd)
			CMD_TICK: begin
				nxt.seconds = sec_inc;
				if (sec_inc == 6'd0) begin
					nxt.minutes = min_inc;
					if (min_inc == 6'd0) begin
						nxt.hours = hour_inc;
					end
				end
				match = (nxt.hours == cur.alarm_hours) && (nxt.minutes == cur.alarm_minutes);
				if (cur.alarm_enabled) begin
					nxt.is_ringing = match;
					started = match && !cur.is_ringing;
				end
			end
			CMD_HOUR_UP: begin
				if (req.edit_alarm) nxt.alarm_hours = ahour_inc;
				else nxt.hours = hour_inc;
			end
			CMD_HOUR_DN: begin
				if (req.edit_alarm) nxt.alarm_hours = ahour_dec;
				else nxt.hours = hour_dec;
			end
			CMD_MIN_UP: begin
				if (req.edit_alarm) nxt.alarm_minutes = amin_inc;
				else nxt.minutes = min_inc;
			end
			CMD_MIN_DN: begin
				if (req.edit_alarm) nxt.alarm_minutes = amin_dec;
				else nxt.minutes = min_dec;
			end
			CMD_SNOOZE: begin
				if (cur.is_ringing) begin
					nxt.is_ringing = 1'b0;
					if (snooze_sum >= {1'b0, MIN_MOD}) begin
						nxt.alarm_minutes = 6'(snooze_sum - {1'b0, MIN_MOD});
						nxt.alarm_hours   = ahour_inc;
					end else begin
						nxt.alarm_minutes = snooze_sum[5:0];
					end
				end
			end
			CMD_TOGGLE: begin
				nxt.alarm_enabled = !cur.alarm_enabled;
				nxt.is_ringing    = 1'b0;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	// Format the display and status
	always_comb begin
		disp_hour = nxt.hours;
		pm        = 1'b0;
		if (twelve_hour) begin
			if (nxt.hours >= NOON) begin
				pm = 1'b1;
				if (nxt.hours > NOON) disp_hour = nxt.hours - NOON;
			end else if (nxt.hours == 5'd0) begin
				disp_hour = NOON;
			end
		end
		rsp.shown_time    = 12'(disp_hour) * HOUR_SCALE + 12'(nxt.minutes);
		rsp.pm            = pm;
		rsp.alarm_setting = 12'(nxt.alarm_hours) * HOUR_SCALE + 12'(nxt.alarm_minutes);
		rsp.ringing       = nxt.is_ringing;
		rsp.alarm_armed   = nxt.alarm_enabled;
		rsp.ring_start    = started;
	end

endmodule

// ----- sv/alarm_clock_core_unit.sv -----
`timescale 1ns / 1ps
// Alarm clock core: one request in, one status result out.
// From request accept to result valid a request passes the request register,
// then the result register; throughput: one request per cycle while rsp_ready does not stall results.
// The state update is a single step of the time path between those registers.
// Reset (arst_n low, asynchronous): time, alarm, enable and ringing clear,
// twelve_hour clears and snooze_minutes returns to 1.
`include "alarm_clock_core_unit_macros.svh"
module alarm_clock_core_unit import acc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        req_valid,
	output logic        req_ready,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output rsp_t        rsp
);

	logic       twelve_hour_q;
	logic [3:0] snooze_q;
	logic       valid_s1;
	req_t       req_s1;
	clk_state_t state_q;
	clk_state_t state_nxt;
	rsp_t       rsp_nxt;
	rsp_t       rsp_q;
	logic       rsp_valid_q;
	logic       advance;
	logic       cfg_wr;

	// Register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	always_comb begin
		unique case (paddr[2])
			REG_TWELVE_HOUR: prdata = {31'd0, twelve_hour_q};
			REG_SNOOZE:      prdata = {28'd0, snooze_q};
			default:         prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			twelve_hour_q <= 1'b0;
			snooze_q      <= SNOOZE_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_TWELVE_HOUR) twelve_hour_q <= pwdata[0];
			else snooze_q <= pwdata[3:0];
		end
	end

	// Flow control: move the held request on when the result slot is free
	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;

	// Request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) req_s1 <= req;
	end

	acc_time_path u_time_path (
		.cur            (state_q),
		.req            (req_s1),
		.twelve_hour    (twelve_hour_q),
		.snooze_minutes (snooze_q),
		.nxt            (state_nxt),
		.rsp            (rsp_nxt)
	);

	// Clock state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q     <= state_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) rsp_q <= rsp_nxt;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Checks
	`ACC_ASSERT_IMP(a_start_rings, clk, arst_n, rsp_valid_q && rsp_q.ring_start, rsp_q.ringing)
	`ACC_ASSERT_IMP(a_ring_armed, clk, arst_n, state_q.is_ringing, state_q.alarm_enabled)
	`ACC_ASSERT_IMP(a_time_range, clk, arst_n, 1'b1, (state_q.minutes < MIN_MOD) && (state_q.seconds < SEC_MOD) && (state_q.hours < HOUR_MOD) && (state_q.alarm_minutes < MIN_MOD) && (state_q.alarm_hours < HOUR_MOD))
	`ACC_ASSERT_NXT(a_state_hold, clk, arst_n, !advance, $stable(state_q))

endmodule

// ----- tb/acc_status_checker.sv -----
`timescale 1ns / 1ps
module acc_status_checker import acc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        req_valid,
	input  logic        req_ready,
	input  req_t        req,
	input  logic        rsp_valid,
	input  logic        rsp_ready,
	input  rsp_t        rsp,
	output int          mismatches,
	output int          pending
);

	clk_state_t clock_now;
	logic       twelve_mode;
	logic [3:0] snooze_len;
	rsp_t       status_due[$];

	function automatic int wrap_up(input int v, input int modulus);
		return (v + 1 >= modulus) ? 0 : v + 1;
	endfunction

	function automatic int wrap_down(input int v, input int modulus);
		return (v == 0 || v >= modulus) ? modulus - 1 : v - 1;
	endfunction

	// Apply one request to the local clock copy and build the status it reports
	function automatic rsp_t advance_clock(input req_t r);
		rsp_t s;
		int   m;
		int   hh;
		s = '0;
		case (r.cmd)
			CMD_TICK: begin
				clock_now.seconds = 6'(wrap_up(clock_now.seconds, SEC_MOD));
				if (clock_now.seconds == 0) begin
					clock_now.minutes = 6'(wrap_up(clock_now.minutes, MIN_MOD));
					if (clock_now.minutes == 0)
						clock_now.hours = 5'(wrap_up(clock_now.hours, HOUR_MOD));
				end
				// only an armed alarm follows the comparison
				if (clock_now.alarm_enabled) begin
					if (clock_now.hours == clock_now.alarm_hours &&
					    clock_now.minutes == clock_now.alarm_minutes) begin
						s.ring_start = !clock_now.is_ringing;
						clock_now.is_ringing = 1'b1;
					end else begin
						clock_now.is_ringing = 1'b0;
					end
				end
			end
			CMD_HOUR_UP: begin
				if (r.edit_alarm)
					clock_now.alarm_hours = 5'(wrap_up(clock_now.alarm_hours, HOUR_MOD));
				else
					clock_now.hours = 5'(wrap_up(clock_now.hours, HOUR_MOD));
			end
			CMD_HOUR_DN: begin
				if (r.edit_alarm)
					clock_now.alarm_hours = 5'(wrap_down(clock_now.alarm_hours, HOUR_MOD));
				else
					clock_now.hours = 5'(wrap_down(clock_now.hours, HOUR_MOD));
			end
			CMD_MIN_UP: begin
				if (r.edit_alarm)
					clock_now.alarm_minutes = 6'(wrap_up(clock_now.alarm_minutes, MIN_MOD));
				else
					clock_now.minutes = 6'(wrap_up(clock_now.minutes, MIN_MOD));
			end
			CMD_MIN_DN: begin
				if (r.edit_alarm)
					clock_now.alarm_minutes = 6'(wrap_down(clock_now.alarm_minutes, MIN_MOD));
				else
					clock_now.minutes = 6'(wrap_down(clock_now.minutes, MIN_MOD));
			end
			CMD_SNOOZE: begin
				// push the alarm back, carrying into the hour
				if (clock_now.is_ringing) begin
					m = clock_now.alarm_minutes + snooze_len;
					clock_now.is_ringing = 1'b0;
					if (m >= MIN_MOD) begin
						m = m - MIN_MOD;
						clock_now.alarm_hours = 5'(wrap_up(clock_now.alarm_hours, HOUR_MOD));
					end
					clock_now.alarm_minutes = 6'(m);
				end
			end
			CMD_TOGGLE: begin
				clock_now.alarm_enabled = !clock_now.alarm_enabled;
				clock_now.is_ringing    = 1'b0;
			end
			default: ;
		endcase

		// display form of the clock
		hh = clock_now.hours;
		if (twelve_mode) begin
			if (hh >= NOON) begin
				s.pm = 1'b1;
				if (hh > NOON)
					hh = hh - NOON;
			end else if (hh == 0) begin
				hh = NOON;
			end
		end
		s.shown_time    = 12'(hh * HOUR_SCALE + clock_now.minutes);
		s.alarm_setting = 12'(clock_now.alarm_hours * HOUR_SCALE + clock_now.alarm_minutes);
		s.ringing       = clock_now.is_ringing;
		s.alarm_armed   = clock_now.alarm_enabled;
		return s;
	endfunction

	task automatic compare_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
		end
	endtask

	// Track register writes, predict on each request, check each result
	always @(posedge clk or negedge arst_n) begin
		rsp_t due;
		if (!arst_n) begin
			clock_now   = '0;
			twelve_mode = 1'b0;
			snooze_len  = SNOOZE_RESET;
			status_due.delete();
			mismatches  = 0;
			pending     = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr)
					{REG_TWELVE_HOUR, 2'b00}: twelve_mode = pwdata[0];
					{REG_SNOOZE, 2'b00}:      snooze_len  = pwdata[3:0];
					default: ;
				endcase
			end
			if (rsp_valid && rsp_ready) begin
				if (status_due.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, expected none, actual %p", $time, rsp);
				end else begin
					due = status_due.pop_front();
					compare_field("shown_time", due.shown_time, rsp.shown_time);
					compare_field("pm", due.pm, rsp.pm);
					compare_field("alarm_setting", due.alarm_setting, rsp.alarm_setting);
					compare_field("ringing", due.ringing, rsp.ringing);
					compare_field("alarm_armed", due.alarm_armed, rsp.alarm_armed);
					compare_field("ring_start", due.ring_start, rsp.ring_start);
				end
			end
			if (req_valid && req_ready)
				status_due.push_back(advance_clock(req));
			pending = status_due.size();
		end
	end

endmodule

// ----- tb/tb_alarm_clock_core_unit.sv -----
`timescale 1ns / 1ps
module tb_alarm_clock_core_unit;
	import acc_pkg::*;

	localparam int SEG_ITEMS = 200;
	localparam int SEG_COUNT = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        req_valid = 1'b0;
	logic        req_ready;
	req_t        req = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	rsp_t        rsp;
	int          mismatches;
	int          pending;

	int          items_sent = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	logic        twelve_cfg = 1'b0;
	rsp_t        last_status = '0;

	always #5 clk = ~clk;

	alarm_clock_core_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	acc_status_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// Stall the result side at random
	always @(negedge clk)
		rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

	// Hold the latest status so the stimulus can steer towards the alarm
	always @(posedge clk)
		if (rsp_valid && rsp_ready)
			last_status <= rsp;

	task automatic issue(input logic [2:0] c, input logic on_alarm);
		req_t r;
		r.cmd        = c;
		r.edit_alarm = on_alarm;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req_valid = 1'b1;
		req       = r;
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
		items_sent++;
	endtask

	// Drop valid and wait for every outstanding result
	task automatic drain();
		req_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [3:0] val);
		logic [31:0] wdata;
		drain();
		wdata = $urandom();
		if (idx == REG_TWELVE_HOUR) begin
			wdata[0]   = val[0];
			twelve_cfg = val[0];
		end else begin
			wdata[3:0] = val;
		end
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = wdata;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// Step a wrapping field the short way round
	task automatic step_toward(input logic [2:0] up_cmd, input logic [2:0] dn_cmd,
	                           input logic on_alarm, input int from, input int to,
	                           input int modulus);
		int up;
		up = (to - from + modulus) % modulus;
		if (up <= modulus / 2)
			repeat (up) issue(up_cmd, on_alarm);
		else
			repeat (modulus - up) issue(dn_cmd, on_alarm);
	endtask

	// Line the clock and alarm up or roll over midnight, arm if needed, tick on, then react
	task automatic ring_scenario();
		int ch, cm, ah, am, kind, n;
		logic lead;
		drain();
		ch = last_status.shown_time / 100;
		cm = last_status.shown_time % 100;
		if (twelve_cfg) begin
			if (last_status.pm && ch != NOON)
				ch = ch + NOON;
			else if (!last_status.pm && ch == NOON)
				ch = 0;
		end
		ah   = last_status.alarm_setting / 100;
		am   = last_status.alarm_setting % 100;
		kind = $urandom_range(9);
		n    = $urandom_range(1, 3);
		if (kind == 0) begin
			// roll the clock over midnight
			step_toward(CMD_HOUR_UP, CMD_HOUR_DN, 1'b0, ch, 23, 24);
			step_toward(CMD_MIN_UP, CMD_MIN_DN, 1'b0, cm, 59, 60);
			n = 61;
		end else if (kind < 3) begin
			step_toward(CMD_HOUR_UP, CMD_HOUR_DN, 1'b0, ch, ah, 24);
			step_toward(CMD_MIN_UP, CMD_MIN_DN, 1'b0, cm, am, 60);
		end else begin
			lead = (kind == 3);
			step_toward(CMD_HOUR_UP, CMD_HOUR_DN, 1'b1, ah, ch, 24);
			step_toward(CMD_MIN_UP, CMD_MIN_DN, 1'b1, am, (cm + lead) % 60, 60);
			if (lead)
				n = 61;
		end
		if (!last_status.alarm_armed && (kind != 0 || $urandom_range(1)))
			issue(CMD_TOGGLE, 1'($urandom_range(1)));
		repeat (n) issue(CMD_TICK, 1'($urandom_range(1)));
		case ($urandom_range(3))
			0: begin
				issue(CMD_SNOOZE, 1'($urandom_range(1)));
				repeat ($urandom_range(1, 3)) issue(CMD_TICK, 1'($urandom_range(1)));
			end
			1: issue(CMD_TOGGLE, 1'($urandom_range(1)));
			2: repeat (2) issue(CMD_SNOOZE, 1'($urandom_range(1)));
			default: ;
		endcase
	endtask

	initial begin
		int seg;
		int seg_end;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: ring at midnight, snooze, wraps of every edit but alarm minute up
		issue(CMD_TOGGLE, 1'b0);
		issue(CMD_TICK, 1'b1);
		issue(CMD_TICK, 1'b0);
		issue(CMD_SNOOZE, 1'b0);
		issue(CMD_SNOOZE, 1'b1);
		issue(CMD_NOP, 1'b1);
		issue(CMD_HOUR_DN, 1'b0);
		issue(CMD_HOUR_UP, 1'b0);
		issue(CMD_MIN_DN, 1'b0);
		issue(CMD_MIN_UP, 1'b0);
		issue(CMD_MIN_DN, 1'b1);
		issue(CMD_MIN_DN, 1'b1);
		issue(CMD_HOUR_DN, 1'b1);
		issue(CMD_HOUR_UP, 1'b1);
		issue(CMD_MIN_DN, 1'b0);
		issue(CMD_TICK, 1'b0);
		// snooze across the hour with the longest delay
		write_reg(REG_SNOOZE, 4'd15);
		issue(CMD_SNOOZE, 1'b0);
		issue(CMD_TOGGLE, 1'b1);
		issue(CMD_TICK, 1'b0);
		// twelve hour display around midnight
		write_reg(REG_TWELVE_HOUR, 4'd1);
		issue(CMD_NOP, 1'b0);
		issue(CMD_HOUR_DN, 1'b0);
		issue(CMD_HOUR_UP, 1'b0);

		// Random: idle patterns change over the segments, settings per segment
		for (seg = 0; seg < SEG_COUNT; seg++) begin
			if (seg < 3) begin
				send_idle_pct = 14;
				recv_idle_pct = 85;
			end else if (seg < 6) begin
				send_idle_pct = 85;
				recv_idle_pct = 14;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (seg)
				0: write_reg(REG_SNOOZE, 4'd10);
				1: write_reg(REG_SNOOZE, 4'd0);
				2: write_reg(REG_SNOOZE, 4'd15);
				3: write_reg(REG_SNOOZE, 4'd1);
				default: write_reg(REG_SNOOZE, 4'($urandom_range(15)));
			endcase
			write_reg(REG_TWELVE_HOUR, (seg < 4) ? 4'(seg % 2) : 4'($urandom_range(1)));
			seg_end = items_sent + SEG_ITEMS;
			while (items_sent < seg_end) begin
				if ($urandom_range(9) < 6)
					ring_scenario();
				else
					repeat ($urandom_range(1, 6))
						issue(3'($urandom_range(7)), 1'($urandom_range(1)));
			end
		end

		drain();
		repeat (10) @(negedge clk);
		if (mismatches == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Hard stop on a hung handshake
	initial begin
		#5000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
